>>> rtl/core/quadrature_dial_to_circle_motion_assert.svh
// assertion macros for the quadrature dial to circle motion block
// used by the top level only, needs no package
`ifndef QUADRATURE_DIAL_TO_CIRCLE_MOTION_ASSERT_SVH
`define QUADRATURE_DIAL_TO_CIRCLE_MOTION_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, checked out of reset
`define QDCM_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define QDCM_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);
`else
`define QDCM_ASSERT_IMP(label, clk, rst, cond, prop, msg)
`define QDCM_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

>>> rtl/core/qdcm_pkg.sv
// shared types, constants and table functions of the dial to circle motion block
// no dependencies
package qdcm_pkg;

  // fixed field widths
  localparam int RADIUS_W   = 8;
  localparam int MOTION_W   = 16;
  localparam int POSITION_W = 9;
  // scaled table value width: entry (frac+3) times radius (9 signed) less frac bits
  localparam int SCALE_W    = 12;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 8'd10;

  // angle constants in Q30
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  // gray-code rank differences
  localparam logic [1:0] DIFF_CW  = 2'd1;
  localparam logic [1:0] DIFF_CCW = 2'd3;

  typedef struct packed {
    logic pin_a_level;
    logic pin_b_level;
  } in_word_t;

  typedef struct packed {
    logic signed [MOTION_W-1:0] move_x;
    logic signed [MOTION_W-1:0] move_y;
    logic [POSITION_W-1:0]      new_position;
    logic                       turned_clockwise;
  } out_word_t;

  typedef logic [RADIUS_W-1:0] cfg_word_t;

  // decoded step of the dial
  typedef struct packed {
    logic moved;
    logic cw;
    logic reversal;
  } move_t;

  // sine or cosine magnitude of 0..45 degrees in Q30 (taylor series)
  function automatic longint unsigned octant_value(input int unsigned r,
                                                   input logic want_sin);
    longint unsigned r64;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint          sum;
    longint unsigned s_res;
    longint unsigned c_res;
    r64 = longint'(r);
    x   = (r64 * PI_Q30 + 64'd90) / 64'd180;
    x2  = (x * x) >> 30;
    // sine terms
    t   = x;
    sum = longint'(x);
    t = ((t * x2) >> 30) / 64'd6;   sum = sum - longint'(t);
    t = ((t * x2) >> 30) / 64'd20;  sum = sum + longint'(t);
    t = ((t * x2) >> 30) / 64'd42;  sum = sum - longint'(t);
    t = ((t * x2) >> 30) / 64'd72;  sum = sum + longint'(t);
    t = ((t * x2) >> 30) / 64'd110; sum = sum - longint'(t);
    t = ((t * x2) >> 30) / 64'd156; sum = sum + longint'(t);
    t = ((t * x2) >> 30) / 64'd210; sum = sum - longint'(t);
    s_res = (sum < 0) ? 64'd0 : longint'(sum);
    // cosine terms
    t   = ONE_Q30;
    sum = longint'(ONE_Q30);
    t = ((t * x2) >> 30) / 64'd2;   sum = sum - longint'(t);
    t = ((t * x2) >> 30) / 64'd12;  sum = sum + longint'(t);
    t = ((t * x2) >> 30) / 64'd30;  sum = sum - longint'(t);
    t = ((t * x2) >> 30) / 64'd56;  sum = sum + longint'(t);
    t = ((t * x2) >> 30) / 64'd90;  sum = sum - longint'(t);
    t = ((t * x2) >> 30) / 64'd132; sum = sum + longint'(t);
    t = ((t * x2) >> 30) / 64'd182; sum = sum - longint'(t);
    t = ((t * x2) >> 30) / 64'd240; sum = sum + longint'(t);
    c_res = (sum < 0) ? 64'd0 : longint'(sum);
    return want_sin ? s_res : c_res;
  endfunction

  // cosine or sine of an integer degree, rounded to frac fraction bits
  function automatic longint deg_value(input int unsigned d, input int unsigned frac,
                                       input logic want_cos);
    int unsigned     dm;
    int unsigned     q;
    int unsigned     r;
    int unsigned     sh;
    longint unsigned s0;
    longint unsigned c0;
    longint          s;
    longint          c;
    longint          cv;
    longint          sv;
    dm = d % 360;
    q  = dm / 90;
    r  = dm % 90;
    if (r <= 45) begin
      s0 = octant_value(r, 1'b1);
      c0 = octant_value(r, 1'b0);
    end else begin
      c0 = octant_value(90 - r, 1'b1);
      s0 = octant_value(90 - r, 1'b0);
    end
    sh = 30 - frac;
    s  = longint'((s0 + (64'd1 << (sh - 1))) >> sh);
    c  = longint'((c0 + (64'd1 << (sh - 1))) >> sh);
    case (q)
      0: begin
        cv = c;
        sv = s;
      end
      1: begin
        cv = -s;
        sv = c;
      end
      2: begin
        cv = -c;
        sv = -s;
      end
      default: begin
        cv = s;
        sv = -c;
      end
    endcase
    return want_cos ? cv : sv;
  endfunction

endpackage

>>> rtl/core/qdcm_chan_if.sv
// valid/ready channel carrying one word of a given payload type
// payload types come from qdcm_pkg
interface qdcm_chan_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/qdcm_decoder.sv
// gray-code step decoder and position stepping with wrap-around
// depends on qdcm_pkg
module qdcm_decoder #(
  parameter int STEP_COUNT = 24,
  parameter int POS_W      = 5
) (
  input  logic [1:0]       pin_code,
  input  logic [1:0]       pin_state,
  input  logic [POS_W-1:0] position,
  input  logic             last_cw,
  output qdcm_pkg::move_t  mv,
  output logic [POS_W-1:0] next_pos
);

  logic [1:0] rank_new;
  logic [1:0] rank_old;
  logic [1:0] diff;

  // rank along the clockwise cycle 00 -> 10 -> 11 -> 01
  function automatic logic [1:0] gray_rank(input logic [1:0] code);
    logic [1:0] rank;
    case (code)
      2'b00:   rank = 2'd0;
      2'b01:   rank = 2'd3;
      2'b10:   rank = 2'd1;
      default: rank = 2'd2;
    endcase
    return rank;
  endfunction

  // classify the change of the pin pair
  always_comb begin
    rank_new = gray_rank(pin_code);
    rank_old = gray_rank(pin_state);
    diff     = rank_new - rank_old;
    mv.moved    = (diff == qdcm_pkg::DIFF_CW) || (diff == qdcm_pkg::DIFF_CCW);
    mv.cw       = (diff == qdcm_pkg::DIFF_CW);
    mv.reversal = mv.moved && (mv.cw != last_cw);
  end

  // step the position, wrapping at both ends
  always_comb begin
    if (mv.cw) begin
      next_pos = (position == POS_W'(STEP_COUNT - 1)) ? '0 : position + POS_W'(1);
    end else begin
      next_pos = (position == '0) ? POS_W'(STEP_COUNT - 1) : position - POS_W'(1);
    end
  end

endmodule

>>> rtl/core/qdcm_axis_scale.sv
// one axis of the motion: table entries scaled by radius, truncated toward zero,
// with the reversal correction added; depends on qdcm_pkg
module qdcm_axis_scale #(
  parameter int ENTRY_W   = 17,
  parameter int FRAC_BITS = 14
) (
  input  logic signed [ENTRY_W-1:0]            entry_now,
  input  logic signed [ENTRY_W-1:0]            entry_prev,
  input  logic [qdcm_pkg::RADIUS_W-1:0]        radius,
  input  qdcm_pkg::move_t                      mv,
  output logic signed [qdcm_pkg::MOTION_W-1:0] motion_out
);

  localparam int PROD_W  = ENTRY_W + qdcm_pkg::RADIUS_W + 1;
  localparam int SCALE_W = qdcm_pkg::SCALE_W;
  localparam int SUM_W   = SCALE_W + 1;
  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'((1 << FRAC_BITS) - 1);

  logic signed [PROD_W-1:0]  radius_s;
  logic signed [PROD_W-1:0]  prod_now;
  logic signed [PROD_W-1:0]  prod_prev;
  logic signed [SCALE_W-1:0] val_now;
  logic signed [SCALE_W-1:0] val_prev;
  logic signed [SCALE_W-1:0] val_rev;
  logic signed [SUM_W-1:0]   sum;

  // drop fraction bits, rounding toward zero
  function automatic logic signed [SCALE_W-1:0] trunc0(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] pb;
    pb = p + (p[PROD_W-1] ? ROUND_BIAS : PROD_W'(0));
    return SCALE_W'(pb >>> FRAC_BITS);
  endfunction

  // products with the radius
  always_comb begin
    radius_s  = PROD_W'($signed({1'b0, radius}));
    prod_now  = PROD_W'(entry_now) * radius_s;
    prod_prev = PROD_W'(entry_prev) * radius_s;
    val_now   = trunc0(prod_now);
    val_prev  = trunc0(prod_prev);
  end

  // main term and, on reversal, the previous step, both signed by the new direction
  always_comb begin
    val_rev = mv.reversal ? val_prev : '0;
    if (mv.cw) begin
      sum = SUM_W'(val_now) + SUM_W'(val_rev);
    end else begin
      sum = -(SUM_W'(val_now) + SUM_W'(val_rev));
    end
    // sum stays well inside 16 bits, so no clipping is reached
    motion_out = qdcm_pkg::MOTION_W'(sum);
  end

endmodule

>>> rtl/core/quadrature_dial_to_circle_motion.sv
// Quadrature dial to circle motion: top level with state, table and result register.
// Each accepted pin sample that moves the dial has its motion word registered in the result register.
// Throughput: one sample per cycle; the one-stage decode, table read and radius
// multiply set it. Ready falls only while a result waits on a stalled output.
// Reset (synchronous): pins low, position 0, direction clockwise, radius 10, no result.
// Depends on qdcm_pkg, qdcm_chan_if, qdcm_decoder, qdcm_axis_scale and the assert header.
`include "quadrature_dial_to_circle_motion_assert.svh"
module quadrature_dial_to_circle_motion #(
  parameter int STEP_COUNT          = 24,
  parameter int TABLE_FRACTION_BITS = 14
) (
  input logic         clk,
  input logic         rst,
  qdcm_chan_if.sink   cfg,
  qdcm_chan_if.sink   sample,
  qdcm_chan_if.source motion
);

  localparam int POS_W   = $clog2(STEP_COUNT);
  localparam int ENTRY_W = TABLE_FRACTION_BITS + 3;
  localparam int SPAN    = 360 / STEP_COUNT;

  logic signed [ENTRY_W-1:0] tab_dx [STEP_COUNT];
  logic signed [ENTRY_W-1:0] tab_dy [STEP_COUNT];

  logic [qdcm_pkg::RADIUS_W-1:0] radius;
  logic [1:0]                    pin_state;
  logic [POS_W-1:0]              position;
  logic                          last_cw;
  logic signed [ENTRY_W-1:0]     cur_dx;
  logic signed [ENTRY_W-1:0]     cur_dy;
  logic                          out_valid;
  qdcm_pkg::out_word_t           out_word;

  logic                                  accept_in;
  logic [1:0]                            pin_code;
  qdcm_pkg::move_t                       mv;
  logic [POS_W-1:0]                      next_pos;
  logic signed [ENTRY_W-1:0]             next_dx;
  logic signed [ENTRY_W-1:0]             next_dy;
  logic signed [qdcm_pkg::MOTION_W-1:0]  move_x_next;
  logic signed [qdcm_pkg::MOTION_W-1:0]  move_y_next;

  // motion table: difference of successive circle points, built at elaboration
  for (genvar k = 0; k < STEP_COUNT; k++) begin : g_tab
    localparam int PREV_K = (k == 0) ? STEP_COUNT - 1 : k - 1;
    assign tab_dx[k] = ENTRY_W'(
        qdcm_pkg::deg_value(k * SPAN, TABLE_FRACTION_BITS, 1'b1) -
        qdcm_pkg::deg_value(PREV_K * SPAN, TABLE_FRACTION_BITS, 1'b1));
    assign tab_dy[k] = ENTRY_W'(
        qdcm_pkg::deg_value(k * SPAN, TABLE_FRACTION_BITS, 1'b0) -
        qdcm_pkg::deg_value(PREV_K * SPAN, TABLE_FRACTION_BITS, 1'b0));
  end

  // handshakes
  assign cfg.ready    = 1'b1;
  assign sample.ready = !out_valid || motion.ready;
  assign accept_in    = sample.valid && sample.ready;
  assign pin_code     = {sample.data.pin_a_level, sample.data.pin_b_level};

  // step decode
  qdcm_decoder #(
    .STEP_COUNT (STEP_COUNT),
    .POS_W      (POS_W)
  ) u_decoder (
    .pin_code  (pin_code),
    .pin_state (pin_state),
    .position  (position),
    .last_cw   (last_cw),
    .mv        (mv),
    .next_pos  (next_pos)
  );

  // table read at the new position; the old one is held in cur_dx/cur_dy
  assign next_dx = tab_dx[next_pos];
  assign next_dy = tab_dy[next_pos];

  qdcm_axis_scale #(
    .ENTRY_W   (ENTRY_W),
    .FRAC_BITS (TABLE_FRACTION_BITS)
  ) u_axis_x (
    .entry_now  (next_dx),
    .entry_prev (cur_dx),
    .radius     (radius),
    .mv         (mv),
    .motion_out (move_x_next)
  );

  qdcm_axis_scale #(
    .ENTRY_W   (ENTRY_W),
    .FRAC_BITS (TABLE_FRACTION_BITS)
  ) u_axis_y (
    .entry_now  (next_dy),
    .entry_prev (cur_dy),
    .radius     (radius),
    .mv         (mv),
    .motion_out (move_y_next)
  );

  // radius register
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= qdcm_pkg::RADIUS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      radius <= cfg.data;
    end
  end

  // dial state
  always_ff @(posedge clk) begin
    if (rst) begin
      pin_state <= 2'b00;
      position  <= '0;
      last_cw   <= 1'b1;
      cur_dx    <= tab_dx[0];
      cur_dy    <= tab_dy[0];
    end else if (accept_in) begin
      pin_state <= pin_code;
      if (mv.moved) begin
        position <= next_pos;
        last_cw  <= mv.cw;
        cur_dx   <= next_dx;
        cur_dy   <= next_dy;
      end
    end
  end

  // result word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept_in && mv.moved) begin
      out_valid <= 1'b1;
    end else if (motion.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (accept_in && mv.moved) begin
      out_word.move_x           <= move_x_next;
      out_word.move_y           <= move_y_next;
      out_word.new_position     <= qdcm_pkg::POSITION_W'(next_pos);
      out_word.turned_clockwise <= mv.cw;
    end
  end

  assign motion.valid = out_valid;
  assign motion.data  = out_word;

  // checks
  `QDCM_ASSERT_IMP(a_ready_only_on_stall, clk, rst, !sample.ready, motion.valid && !motion.ready, "sample stalled without a waiting result")
  `QDCM_ASSERT_NEXT(a_idle_word_drains, clk, rst, accept_in && !mv.moved && motion.ready, !motion.valid, "result shown for a sample with no move")
  `QDCM_ASSERT_IMP(a_word_matches_state, clk, rst, motion.valid, (motion.data.new_position == qdcm_pkg::POSITION_W'(position)) && (motion.data.turned_clockwise == last_cw), "result word disagrees with dial state")
  `QDCM_ASSERT_IMP(a_position_in_range, clk, rst, 1'b1, 32'(position) < 32'(STEP_COUNT), "position beyond step count")

endmodule
